>>> hdl/four_digit_seven_segment_encoder_assert.svh
// assertion macros used by the checker file
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_ASSERT_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_ASSERT_SVH

// property checked while out of reset
`define SEVSEG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define SEVSEG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sevseg_pkg.sv
// ----------------------------------------------------------------------------
// sevseg_pkg
// Types, constants and code tables for the four-digit seven-segment encoder.
// ----------------------------------------------------------------------------
package sevseg_pkg;

   localparam int VALUE_W = 14;
   localparam int SEG_W   = 8;
   localparam int SEL_W   = 8;
   localparam int IDX_W   = 2;
   localparam int DIGIT_W = 4;

   localparam logic [VALUE_W-1:0] MAX_SHOWN  = 14'd9999;
   localparam logic [IDX_W-1:0]   IDX_THOU   = 2'd0;
   localparam logic [IDX_W-1:0]   IDX_HUND   = 2'd1;
   localparam logic [IDX_W-1:0]   IDX_TENS   = 2'd2;
   localparam logic [IDX_W-1:0]   IDX_UNITS  = 2'd3;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } sevseg_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sevseg_qstat_type;

   // active-low common-anode patterns, bit0 segment a
   function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = 8'h90;
      endcase
      return s;
   endfunction

   function automatic logic [SEL_W-1:0] sel_code(input logic [IDX_W-1:0] idx);
      logic [SEL_W-1:0] s;
      case (idx)
         IDX_THOU:  s = 8'hF1;
         IDX_HUND:  s = 8'hF2;
         IDX_TENS:  s = 8'hF4;
         IDX_UNITS: s = 8'hF8;
         default:   s = 8'hF8;
      endcase
      return s;
   endfunction

   function automatic logic [VALUE_W-1:0] place_weight(input logic [IDX_W-1:0] idx);
      logic [VALUE_W-1:0] w;
      case (idx)
         IDX_THOU:  w = 14'd1000;
         IDX_HUND:  w = 14'd100;
         IDX_TENS:  w = 14'd10;
         IDX_UNITS: w = 14'd1;
         default:   w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

>>> hdl/sevseg_if.sv
// ----------------------------------------------------------------------------
// sevseg_if
// Valid/ready channels: binary value in, one digit result out.
// ----------------------------------------------------------------------------
interface sevseg_req_if;
   logic                            valid;
   logic                            ready;
   logic [sevseg_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sevseg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sevseg_pkg::SEG_W-1:0]  segment_pattern;
   logic [sevseg_pkg::SEL_W-1:0]  digit_select;
   logic [sevseg_pkg::IDX_W-1:0]  digit_index;
   logic                          last_digit;

   modport source (output valid, output segment_pattern, output digit_select,
                   output digit_index, output last_digit, input ready);
   modport sink   (input valid, input segment_pattern, input digit_select,
                   input digit_index, input last_digit, output ready);
endinterface

>>> hdl/sevseg_queue.sv
// ----------------------------------------------------------------------------
// sevseg_queue
// Two-entry queue of saturated values between front and back.
// ----------------------------------------------------------------------------
module sevseg_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  sevseg_pkg::sevseg_push_type    push,
   input  logic                           pop,
   output sevseg_pkg::sevseg_qstat_type   qstat,
   output logic [sevseg_pkg::VALUE_W-1:0] head_value
);
   import sevseg_pkg::*;

   logic [VALUE_W-1:0] mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.value;
      end
   end

   assign head_value  = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == 2'd2);
   assign qstat.empty = (count_ff == 2'd0);

endmodule

>>> hdl/sevseg_front.sv
// ----------------------------------------------------------------------------
// sevseg_front
// Accepts values and clamps anything above 9999 before queueing.
// ----------------------------------------------------------------------------
module sevseg_front (
   sevseg_req_if.sink                    req_ch,
   input  sevseg_pkg::sevseg_qstat_type  qstat,
   output sevseg_pkg::sevseg_push_type   push
);
   import sevseg_pkg::*;

   logic over_range;

   assign req_ch.ready = ~qstat.full;
   assign over_range   = (req_ch.value > MAX_SHOWN);

   always_comb begin
      push.valid = req_ch.valid & ~qstat.full;
      push.value = over_range ? MAX_SHOWN : req_ch.value;
   end

endmodule

>>> hdl/sevseg_back.sv
// ----------------------------------------------------------------------------
// sevseg_back
// Splits queued values into digits, one per unstalled cycle, to an output reg.
// ----------------------------------------------------------------------------
module sevseg_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sevseg_pkg::sevseg_qstat_type   qstat,
   input  logic [sevseg_pkg::VALUE_W-1:0] head_value,
   output logic                           pop,
   sevseg_rsp_if.source                   rsp_ch
);
   import sevseg_pkg::*;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic               valid_ff, valid_in;
   logic [SEG_W-1:0]   seg_ff;
   logic [SEL_W-1:0]   sel_ff;
   logic [IDX_W-1:0]   oidx_ff;
   logic               last_ff;

   logic               active;
   logic               advance;
   logic               step;
   logic [VALUE_W-1:0] cur;
   logic [VALUE_W-1:0] weight;
   logic [DIGIT_W-1:0] digit;

   assign active  = (idx_ff != IDX_THOU) | ~qstat.empty;
   assign advance = ~valid_ff | rsp_ch.ready;
   assign step    = active & advance;
   assign pop     = step & (idx_ff == IDX_THOU);

   // thousands digit is taken straight from the queue head
   assign cur    = (idx_ff == IDX_THOU) ? head_value : rem_ff;
   assign weight = place_weight(idx_ff);

   // cur is below ten times the weight, so the digit is a count of thresholds
   always_comb begin
      digit = '0;
      for (int k = 1; k <= 9; k++) begin
         if (cur >= VALUE_W'(k) * weight) begin
            digit = DIGIT_W'(k);
         end
      end
   end

   always_comb begin
      rem_in   = cur - VALUE_W'(digit) * weight;
      idx_in   = step ? idx_ff + 2'd1 : idx_ff;
      valid_in = advance ? active : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= IDX_THOU;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rem_ff  <= rem_in;
         seg_ff  <= seg_code(digit);
         sel_ff  <= sel_code(idx_ff);
         oidx_ff <= idx_ff;
         last_ff <= (idx_ff == IDX_UNITS);
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.segment_pattern = seg_ff;
   assign rsp_ch.digit_select    = sel_ff;
   assign rsp_ch.digit_index     = oidx_ff;
   assign rsp_ch.last_digit      = last_ff;

endmodule

>>> hdl/four_digit_seven_segment_encoder.sv
// ----------------------------------------------------------------------------
// four_digit_seven_segment_encoder
// Binary value to four active-low seven-segment digit results, thousands first.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                       | per value
//  req_ch   | in  | value[13:0]                                   | 1
//  rsp_ch   | out | segment_pattern, digit_select, digit_index,   | 4
//           |     | last_digit                                    |
//
//  One digit result per cycle while results are not stalled; the digit
//  splitter starts the next queued value right after the units digit.
//  Each value is registered in the queue, then in the output register.
//  A two-entry queue lets the input keep taking values while results stall.
//  Synchronous reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_encoder (
   input  logic          clock,
   input  logic          reset,
   sevseg_req_if.sink    req_ch,
   sevseg_rsp_if.source  rsp_ch
);
   import sevseg_pkg::*;

   sevseg_push_type    push;
   sevseg_qstat_type   qstat;
   logic               pop;
   logic [VALUE_W-1:0] head_value;

   sevseg_front u_front (
      .req_ch (req_ch),
      .qstat  (qstat),
      .push   (push)
   );

   sevseg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .qstat      (qstat),
      .head_value (head_value)
   );

   sevseg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_value (head_value),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

>>> hdl/sevseg_checker.sv
// ----------------------------------------------------------------------------
// sevseg_checker
// Port-level checks on the digit result stream.
// ----------------------------------------------------------------------------
`include "four_digit_seven_segment_encoder_assert.svh"

module sevseg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sevseg_pkg::SEG_W-1:0]  rsp_segment_pattern,
   input logic [sevseg_pkg::SEL_W-1:0]  rsp_digit_select,
   input logic [sevseg_pkg::IDX_W-1:0]  rsp_digit_index,
   input logic                          rsp_last_digit
);
   import sevseg_pkg::*;

   logic [IDX_W-1:0] exp_idx_ff, exp_idx_in;

   // digit positions must run 0,1,2,3 and wrap
   assign exp_idx_in = (rsp_valid & rsp_ready) ? exp_idx_ff + 2'd1 : exp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= IDX_THOU;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   `SEVSEG_ASSERT(a_digit_order, clock, reset, rsp_valid |-> (rsp_digit_index == exp_idx_ff), "digit results out of order")
   `SEVSEG_ASSERT(a_last_on_units, clock, reset, rsp_valid |-> (rsp_last_digit == (rsp_digit_index == IDX_UNITS)), "last flag not on units digit")
   `SEVSEG_ASSERT(a_select_matches, clock, reset, rsp_valid |-> (rsp_digit_select == sel_code(rsp_digit_index)), "digit select does not match position")
   `SEVSEG_ASSERT(a_stall_holds, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_segment_pattern, rsp_digit_index})), "stalled item changed")
   `SEVSEG_ASSERT(a_reset_idle, clock, reset, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind four_digit_seven_segment_encoder sevseg_checker u_sevseg_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_segment_pattern (rsp_ch.segment_pattern),
   .rsp_digit_select    (rsp_ch.digit_select),
   .rsp_digit_index     (rsp_ch.digit_index),
   .rsp_last_digit      (rsp_ch.last_digit)
);
